@@ rtl/core/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cpt_pkg
// Types, widths and region codes shared by the closest-point-on-triangle block.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int CW   = 32;             // coordinate width
	localparam int DW   = CW + 1;         // coordinate difference
	localparam int PW   = 2 * DW;         // product of two differences
	localparam int DOTW = PW + 2;         // dot product of differences
	localparam int CRW  = PW + 1;         // cross product component
	localparam int WPW  = 2 * CRW;        // product of two cross components
	localparam int WW   = WPW + 2;        // barycentric weight
	localparam int DENW = WW + 2;         // denominator
	localparam int NUMW = WW + DW + 1;    // numerator
	localparam int QW   = CW + 1;         // quotient magnitude bits
	localparam int RW   = (NUMW > DENW + QW + 1) ? NUMW : DENW + QW + 1;
	localparam int LW   = 34;             // limb width of the split multipliers

	localparam logic [2:0] RG_VA   = 3'd0;
	localparam logic [2:0] RG_VB   = 3'd1;
	localparam logic [2:0] RG_VC   = 3'd2;
	localparam logic [2:0] RG_AB   = 3'd3;
	localparam logic [2:0] RG_BC   = 3'd4;
	localparam logic [2:0] RG_CA   = 3'd5;
	localparam logic [2:0] RG_FACE = 3'd6;

	typedef logic signed [CW-1:0]   cw_t;
	typedef logic signed [DW-1:0]   dw_t;
	typedef logic signed [PW-1:0]   pw_t;
	typedef logic signed [DOTW-1:0] dot_t;
	typedef logic signed [CRW-1:0]  cr_t;
	typedef logic signed [WPW-1:0]  wp_t;
	typedef logic signed [WW-1:0]   ww_t;
	typedef logic signed [DENW-1:0] den_t;
	typedef logic signed [NUMW-1:0] num_t;
	typedef logic signed [LW:0]     op_t;
	typedef logic signed [2*LW+1:0] pp_t;

	typedef struct packed {
		cw_t px;
		cw_t py;
		cw_t pz;
		cw_t ax;
		cw_t ay;
		cw_t az;
		cw_t bx;
		cw_t by_coord;
		cw_t bz;
		cw_t cx;
		cw_t cy;
		cw_t cz;
	} in_t;

	typedef struct packed {
		cw_t        qx;
		cw_t        qy;
		cw_t        qz;
		logic [2:0] region;
		logic       degenerate;
	} out_t;

	typedef struct packed {
		num_t [2:0] num;
		den_t       den;
		cw_t [2:0]  base;
		logic [2:0] region;
		logic       degen;
		logic       div;
	} mid_t;

endpackage

@@ rtl/core/cpt_front.sv @@
// ----------------------------------------------------------------------------
// cpt_front
// Products, region classification and numerator/denominator setup.
// ----------------------------------------------------------------------------
module cpt_front import cpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  query,
	output logic out_valid,
	input  logic out_ready,
	output mid_t out_rec
);

	// vector slots: 0 e01, 1 e02, 2 e12, 3 d0, 4 d1, 5 d2, 6 a, 7 b, 8 c
	localparam int DA [6] = '{3, 4, 3, 5, 4, 5};
	localparam int DB [6] = '{0, 0, 1, 1, 2, 2};
	localparam int XA [4] = '{0, 3, 4, 5};
	localparam int XB [4] = '{1, 4, 5, 3};
	localparam int XS [3] = '{2, 3, 1};

	logic [9:0] vld_q;
	logic       en;

	cw_t  pin [4][3];
	dw_t  vec_c [9][3];
	dw_t  vec_s1 [9][3];
	dw_t  vec_s2 [9][3];
	dw_t  vec_s3 [9][3];
	dw_t  vec_s4 [9][3];
	dw_t  vec_s5 [9][3];
	dw_t  vec_s6 [9][3];
	pw_t  pd_s2 [6][3];
	pw_t  px_s2 [4][6];
	dot_t dot_s3 [6];
	dot_t dot_s4 [6];
	dot_t dot_s5 [6];
	dot_t dot_s6 [6];
	cr_t  cr_s3 [4][3];
	op_t  crh_c [4][3];
	op_t  crl_c [4][3];
	pp_t  pp_s4 [3][3][4];
	wp_t  wp_s5 [3][3];
	ww_t  w_s6 [3];

	logic [2:0] region_c, region_s7, region_s8, region_s9;
	ww_t        c1_c, c2_c, c1_s7, c2_s7;
	logic [3:0] e1_c, e2_c, base_c;
	den_t       den_c, den_s7, den_s8, den_s9;
	dw_t        e1_s7 [3];
	dw_t        e2_s7 [3];
	cw_t        base_s7 [3];
	cw_t        base_s8 [3];
	cw_t        base_s9 [3];
	cw_t        va_s7 [3];
	cw_t        va_s8 [3];
	cw_t        va_s9 [3];
	op_t        c1l_c [4];
	op_t        c2l_c [4];
	pp_t        np_s8 [3][8];
	num_t       p1_s9 [3];
	num_t       p2_s9 [3];
	mid_t       rec_c, rec_s10;

	function automatic pp_t pmul(op_t a, op_t b);
		return pp_t'(a) * pp_t'(b);
	endfunction

	assign en        = !vld_q[9] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[9];
	assign out_rec   = rec_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[8:0], in_valid};
		end
	end

	always_comb begin
		pin[0][0] = query.px;
		pin[0][1] = query.py;
		pin[0][2] = query.pz;
		pin[1][0] = query.ax;
		pin[1][1] = query.ay;
		pin[1][2] = query.az;
		pin[2][0] = query.bx;
		pin[2][1] = query.by_coord;
		pin[2][2] = query.bz;
		pin[3][0] = query.cx;
		pin[3][1] = query.cy;
		pin[3][2] = query.cz;
		for (int k = 0; k < 3; k++) begin
			vec_c[0][k] = DW'(pin[2][k]) - DW'(pin[1][k]);
			vec_c[1][k] = DW'(pin[3][k]) - DW'(pin[1][k]);
			vec_c[2][k] = DW'(pin[3][k]) - DW'(pin[2][k]);
			vec_c[3][k] = DW'(pin[0][k]) - DW'(pin[1][k]);
			vec_c[4][k] = DW'(pin[0][k]) - DW'(pin[2][k]);
			vec_c[5][k] = DW'(pin[0][k]) - DW'(pin[3][k]);
			vec_c[6][k] = DW'(pin[1][k]);
			vec_c[7][k] = DW'(pin[2][k]);
			vec_c[8][k] = DW'(pin[3][k]);
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			for (int c = 0; c < 3; c++) begin
				crh_c[j][c] = op_t'($signed(cr_s3[j][c][CRW-1:LW]));
				crl_c[j][c] = $signed({1'b0, cr_s3[j][c][LW-1:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_c;
			vec_s2 <= vec_s1;
			vec_s3 <= vec_s2;
			vec_s4 <= vec_s3;
			vec_s5 <= vec_s4;
			vec_s6 <= vec_s5;
			dot_s4 <= dot_s3;
			dot_s5 <= dot_s4;
			dot_s6 <= dot_s5;
			for (int i = 0; i < 6; i++) begin
				for (int k = 0; k < 3; k++) begin
					pd_s2[i][k] <= PW'(vec_s1[DA[i]][k]) * PW'(vec_s1[DB[i]][k]);
				end
			end
			for (int j = 0; j < 4; j++) begin
				for (int c = 0; c < 3; c++) begin
					px_s2[j][2*c]   <= PW'(vec_s1[XA[j]][(c+1)%3]) *
						PW'(vec_s1[XB[j]][(c+2)%3]);
					px_s2[j][2*c+1] <= PW'(vec_s1[XA[j]][(c+2)%3]) *
						PW'(vec_s1[XB[j]][(c+1)%3]);
				end
			end
			for (int i = 0; i < 6; i++) begin
				if (i % 2 == 1) begin
					dot_s3[i] <= -(DOTW'(pd_s2[i][0]) + DOTW'(pd_s2[i][1]) +
						DOTW'(pd_s2[i][2]));
				end else begin
					dot_s3[i] <= DOTW'(pd_s2[i][0]) + DOTW'(pd_s2[i][1]) +
						DOTW'(pd_s2[i][2]);
				end
			end
			for (int j = 0; j < 4; j++) begin
				for (int c = 0; c < 3; c++) begin
					cr_s3[j][c] <= CRW'(px_s2[j][2*c]) - CRW'(px_s2[j][2*c+1]);
				end
			end
			for (int t = 0; t < 3; t++) begin
				for (int k = 0; k < 3; k++) begin
					pp_s4[t][k][0] <= pmul(crh_c[0][k], crh_c[XS[t]][k]);
					pp_s4[t][k][1] <= pmul(crh_c[0][k], crl_c[XS[t]][k]);
					pp_s4[t][k][2] <= pmul(crl_c[0][k], crh_c[XS[t]][k]);
					pp_s4[t][k][3] <= pmul(crl_c[0][k], crl_c[XS[t]][k]);
				end
			end
			for (int t = 0; t < 3; t++) begin
				for (int k = 0; k < 3; k++) begin
					wp_s5[t][k] <= (WPW'(pp_s4[t][k][0]) << (2 * LW)) +
						(WPW'(pp_s4[t][k][1]) << LW) +
						(WPW'(pp_s4[t][k][2]) << LW) +
						WPW'(pp_s4[t][k][3]);
				end
			end
			for (int t = 0; t < 3; t++) begin
				w_s6[t] <= WW'(wp_s5[t][0]) + WW'(wp_s5[t][1]) + WW'(wp_s5[t][2]);
			end
		end
	end

	always_comb begin
		region_c = RG_VA;
		c1_c     = '0;
		c2_c     = '0;
		e1_c     = 4'd0;
		e2_c     = 4'd1;
		base_c   = 4'd6;
		den_c    = '0;
		if (dot_s6[0] <= 0 && dot_s6[2] <= 0) begin
			region_c = RG_VA;
		end else if (dot_s6[1] <= 0 && dot_s6[4] <= 0) begin
			region_c = RG_VB;
			base_c   = 4'd7;
		end else if (dot_s6[3] <= 0 && dot_s6[5] <= 0) begin
			region_c = RG_VC;
			base_c   = 4'd8;
		end else if (w_s6[2] <= 0 && dot_s6[0] >= 0 && dot_s6[1] >= 0) begin
			region_c = RG_AB;
			c1_c     = WW'(dot_s6[0]);
			e1_c     = 4'd0;
			den_c    = DENW'(dot_s6[0]) + DENW'(dot_s6[1]);
		end else if (w_s6[0] <= 0 && dot_s6[4] >= 0 && dot_s6[5] >= 0) begin
			region_c = RG_BC;
			c1_c     = WW'(dot_s6[4]);
			e1_c     = 4'd2;
			base_c   = 4'd7;
			den_c    = DENW'(dot_s6[4]) + DENW'(dot_s6[5]);
		end else if (w_s6[1] <= 0 && dot_s6[2] >= 0 && dot_s6[3] >= 0) begin
			region_c = RG_CA;
			c1_c     = WW'(dot_s6[2]);
			e1_c     = 4'd1;
			den_c    = DENW'(dot_s6[2]) + DENW'(dot_s6[3]);
		end else begin
			region_c = RG_FACE;
			c1_c     = w_s6[1];
			c2_c     = w_s6[2];
			den_c    = DENW'(w_s6[0]) + DENW'(w_s6[1]) + DENW'(w_s6[2]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c1l_c[i] = $signed({1'b0, c1_s7[LW*i +: LW]});
			c2l_c[i] = $signed({1'b0, c2_s7[LW*i +: LW]});
		end
		c1l_c[3] = op_t'($signed(c1_s7[WW-1:3*LW]));
		c2l_c[3] = op_t'($signed(c2_s7[WW-1:3*LW]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_s7 <= region_c;
			c1_s7     <= c1_c;
			c2_s7     <= c2_c;
			den_s7    <= den_c;
			for (int k = 0; k < 3; k++) begin
				e1_s7[k]   <= vec_s6[e1_c][k];
				e2_s7[k]   <= vec_s6[e2_c][k];
				base_s7[k] <= CW'(vec_s6[base_c][k]);
				va_s7[k]   <= CW'(vec_s6[6][k]);
			end
			region_s8 <= region_s7;
			den_s8    <= den_s7;
			base_s8   <= base_s7;
			va_s8     <= va_s7;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 4; i++) begin
					np_s8[k][i]   <= pmul(c1l_c[i], op_t'(e1_s7[k]));
					np_s8[k][4+i] <= pmul(c2l_c[i], op_t'(e2_s7[k]));
				end
			end
			region_s9 <= region_s8;
			den_s9    <= den_s8;
			base_s9   <= base_s8;
			va_s9     <= va_s8;
			for (int k = 0; k < 3; k++) begin
				p1_s9[k] <= NUMW'(np_s8[k][0]) + (NUMW'(np_s8[k][1]) << LW) +
					(NUMW'(np_s8[k][2]) << (2 * LW)) + (NUMW'(np_s8[k][3]) << (3 * LW));
				p2_s9[k] <= NUMW'(np_s8[k][4]) + (NUMW'(np_s8[k][5]) << LW) +
					(NUMW'(np_s8[k][6]) << (2 * LW)) + (NUMW'(np_s8[k][7]) << (3 * LW));
			end
			rec_s10 <= rec_c;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rec_c.num[k]  = p1_s9[k] + p2_s9[k];
			rec_c.base[k] = base_s9[k];
		end
		rec_c.den    = den_s9;
		rec_c.region = region_s9;
		rec_c.degen  = 1'b0;
		rec_c.div    = region_s9 inside {[RG_AB:RG_FACE]};
		if (rec_c.div && den_s9 == '0) begin
			rec_c.region = RG_VA;
			rec_c.degen  = 1'b1;
			rec_c.div    = 1'b0;
			for (int k = 0; k < 3; k++) begin
				rec_c.base[k] = va_s9[k];
			end
		end
	end

endmodule

@@ rtl/core/cpt_fifo.sv @@
// ----------------------------------------------------------------------------
// cpt_fifo
// Small register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module cpt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_q, rd_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CNTW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH))
		else $error("queue count beyond depth");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance on push");

	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push && cnt_q == CNTW'(1)) |=> empty)
		else $error("queue not empty after last pop");

endmodule

@@ rtl/core/cpt_back.sv @@
// ----------------------------------------------------------------------------
// cpt_back
// Pipelined rounded division, offset from the base vertex and saturation.
// ----------------------------------------------------------------------------
module cpt_back import cpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mid_t rec,
	output logic out_valid,
	input  logic out_ready,
	output out_t result
);

	localparam int NST = QW + 4;
	localparam int SW  = QW + 3;

	typedef struct packed {
		logic [2:0][RW-1:0] rem;
		logic [2:0][QW-1:0] quo;
		logic [DENW-1:0]    dmag;
		logic [2:0]         neg;
		logic [2:0]         ovf;
		cw_t [2:0]          base;
		logic [2:0]         region;
		logic               degen;
		logic               div;
	} dstg_t;

	logic [NST-1:0]  vld_q;
	logic            en;
	logic [NUMW-1:0] nmag_s1 [3];
	logic [DENW-1:0] dmag_s1;
	logic [2:0]      neg_s1;
	mid_t            rec_s1;
	dstg_t           dv_q [QW+1];
	dstg_t           dv_c [QW+1];

	logic signed [QW+1:0] sq_c [3];
	logic signed [QW+1:0] sq_s2 [3];
	dstg_t                side_s2;
	logic signed [SW-1:0] sum_c [3];
	cw_t                  q_c [3];
	out_t                 res_s3;

	assign en        = !vld_q[NST-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[NST-1];
	assign result    = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	always_comb begin
		dv_c[0].dmag   = dmag_s1;
		dv_c[0].neg    = neg_s1;
		dv_c[0].base   = rec_s1.base;
		dv_c[0].region = rec_s1.region;
		dv_c[0].degen  = rec_s1.degen;
		dv_c[0].div    = rec_s1.div;
		for (int k = 0; k < 3; k++) begin
			dv_c[0].rem[k] = RW'(nmag_s1[k]);
			dv_c[0].quo[k] = '0;
			dv_c[0].ovf[k] = RW'(nmag_s1[k]) >= (RW'(dmag_s1) << QW);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		always_comb begin
			dv_c[j+1] = dv_q[j];
			for (int k = 0; k < 3; k++) begin
				if (dv_q[j].rem[k] >= (RW'(dv_q[j].dmag) << (QW - 1 - j))) begin
					dv_c[j+1].rem[k] = dv_q[j].rem[k] -
						(RW'(dv_q[j].dmag) << (QW - 1 - j));
					dv_c[j+1].quo[k][QW-1-j] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		logic [QW:0] qr;
		for (int k = 0; k < 3; k++) begin
			qr = {1'b0, dv_q[QW].quo[k]} +
				(QW+1)'({dv_q[QW].rem[k], 1'b0} >= (RW+1)'(dv_q[QW].dmag));
			sq_c[k] = dv_q[QW].neg[k] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = SW'(side_s2.base[k]) + SW'(sq_s2[k]);
			if (!side_s2.div) begin
				q_c[k] = side_s2.base[k];
			end else if (side_s2.ovf[k]) begin
				q_c[k] = side_s2.neg[k] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			end else if (sum_c[k] > SW'(cw_t'({1'b0, {(CW-1){1'b1}}}))) begin
				q_c[k] = {1'b0, {(CW-1){1'b1}}};
			end else if (sum_c[k] < SW'(cw_t'({1'b1, {(CW-1){1'b0}}}))) begin
				q_c[k] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				q_c[k] = CW'(sum_c[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s1  <= rec;
			dmag_s1 <= rec.den[DENW-1] ? DENW'(-rec.den) : DENW'(rec.den);
			for (int k = 0; k < 3; k++) begin
				nmag_s1[k] <= rec.num[k][NUMW-1] ? NUMW'(-rec.num[k]) : NUMW'(rec.num[k]);
				neg_s1[k]  <= rec.num[k][NUMW-1] ^ rec.den[DENW-1];
			end
			for (int j = 0; j <= QW; j++) begin
				dv_q[j] <= dv_c[j];
			end
			side_s2 <= dv_q[QW];
			sq_s2   <= sq_c;
			res_s3.qx         <= q_c[0];
			res_s3.qy         <= q_c[1];
			res_s3.qz         <= q_c[2];
			res_s3.region     <= side_s2.region;
			res_s3.degenerate <= side_s2.degen;
		end
	end

endmodule

@@ rtl/core/closest_point_on_triangle.sv @@
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// Closest point on a triangle to a query point, with Voronoi region code.
// ----------------------------------------------------------------------------
// One query is taken per clock and one result leaves per clock once the
// pipeline is full, while neither side stalls. A query passes the front
// (differences, dot and cross products, split weight products, barycentric
// weights, region test, split numerator products), is written into the
// queue between front and back, and then passes the back, where a rounded
// division resolves one quotient bit per stage for all three coordinates.
// A back stall adds its length to the time in the queue. Either side may
// stall; until the queue fills, it lets the front keep accepting while the
// back waits on pop.
// ----------------------------------------------------------------------------
module closest_point_on_triangle import cpt_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  query,
	input  logic pop,
	output logic empty,
	output out_t result
);

	logic f_ready, f_valid, q_full, q_empty, b_ready, b_valid;
	mid_t f_rec, q_rec;

	cpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_ready  (f_ready),
		.query     (query),
		.out_valid (f_valid),
		.out_ready (!q_full),
		.out_rec   (f_rec)
	);

	cpt_fifo #(
		.WIDTH ($bits(mid_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  (f_rec),
		.full   (q_full),
		.pop    (b_ready),
		.rdata  (q_rec),
		.empty  (q_empty)
	);

	cpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!q_empty),
		.in_ready  (b_ready),
		.rec       (q_rec),
		.out_valid (b_valid),
		.out_ready (pop),
		.result    (result)
	);

	assign full  = !f_ready;
	assign empty = !b_valid;

	a_degen_region: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.degenerate) |-> result.region == RG_VA)
		else $error("degenerate transaction without vertex a region");

endmodule

@@ tb/cpt_scoreboard.sv @@
// ----------------------------------------------------------------------------
// cpt_scoreboard
// Predicts the closest point on a triangle and its region for each accepted
// query, and checks each popped result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class cpt_scoreboard;
	typedef logic signed [255:0] wide_t;
	typedef wide_t vec_t [3];

	cpt_pkg::out_t expected_q [$];
	int unsigned   mismatches;

	function new();
		mismatches = 0;
	endfunction

	function automatic wide_t dot3(vec_t x, vec_t y);
		return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
	endfunction

	function automatic void cross3(vec_t x, vec_t y, output vec_t r);
		r[0] = x[1] * y[2] - x[2] * y[1];
		r[1] = x[2] * y[0] - x[0] * y[2];
		r[2] = x[0] * y[1] - x[1] * y[0];
	endfunction

	function automatic void diff3(vec_t x, vec_t y, output vec_t r);
		for (int i = 0; i < 3; i++) r[i] = x[i] - y[i];
	endfunction

	// round to nearest, ties away from zero
	function automatic wide_t div_round(wide_t num, wide_t den);
		wide_t un, ud, q, rm;
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		q  = un / ud;
		rm = un % ud;
		if (2 * rm >= ud) q = q + 1;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic cpt_pkg::cw_t clamp(wide_t x);
		if (x > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
		if (x < -wide_t'(64'sh80000000)) return 32'sh80000000;
		return cpt_pkg::cw_t'(x[31:0]);
	endfunction

	function automatic void note_query(cpt_pkg::in_t q);
		vec_t pt, va, vb, vc, eab, eac, ebc, dpa, dpb, dpc, tmp, nrm, cr, num, base;
		wide_t s_ab, t_ab, s_ac, t_ac, s_bc, t_bc, wa, wb, wc, den;
		logic [2:0] region;
		cpt_pkg::out_t r;
		pt = '{q.px, q.py, q.pz};
		va = '{q.ax, q.ay, q.az};
		vb = '{q.bx, q.by_coord, q.bz};
		vc = '{q.cx, q.cy, q.cz};
		diff3(vb, va, eab);
		diff3(vc, va, eac);
		diff3(vc, vb, ebc);
		diff3(pt, va, dpa);
		diff3(pt, vb, dpb);
		diff3(pt, vc, dpc);
		s_ab = dot3(dpa, eab);
		diff3(va, vb, tmp);
		t_ab = dot3(dpb, tmp);
		s_ac = dot3(dpa, eac);
		diff3(va, vc, tmp);
		t_ac = dot3(dpc, tmp);
		s_bc = dot3(dpb, ebc);
		diff3(vb, vc, tmp);
		t_bc = dot3(dpc, tmp);
		cross3(eab, eac, nrm);
		cross3(dpa, dpb, cr);
		wc = dot3(nrm, cr);
		cross3(dpb, dpc, cr);
		wa = dot3(nrm, cr);
		cross3(dpc, dpa, cr);
		wb = dot3(nrm, cr);
		r.degenerate = 1'b0;
		num = va;
		base = va;
		den = 0;
		if (s_ab <= 0 && s_ac <= 0) region = cpt_pkg::RG_VA;
		else if (t_ab <= 0 && s_bc <= 0) begin
			region = cpt_pkg::RG_VB;
			num = vb;
		end else if (t_ac <= 0 && t_bc <= 0) begin
			region = cpt_pkg::RG_VC;
			num = vc;
		end else if (wc <= 0 && s_ab >= 0 && t_ab >= 0) begin
			region = cpt_pkg::RG_AB;
			den = s_ab + t_ab;
			for (int i = 0; i < 3; i++) num[i] = s_ab * eab[i];
		end else if (wa <= 0 && s_bc >= 0 && t_bc >= 0) begin
			region = cpt_pkg::RG_BC;
			base = vb;
			den = s_bc + t_bc;
			for (int i = 0; i < 3; i++) num[i] = s_bc * ebc[i];
		end else if (wb <= 0 && s_ac >= 0 && t_ac >= 0) begin
			region = cpt_pkg::RG_CA;
			den = s_ac + t_ac;
			for (int i = 0; i < 3; i++) num[i] = s_ac * eac[i];
		end else begin
			region = cpt_pkg::RG_FACE;
			den = wa + wb + wc;
			for (int i = 0; i < 3; i++) num[i] = wb * eab[i] + wc * eac[i];
		end
		if (region >= cpt_pkg::RG_AB) begin
			if (den == 0) begin
				region = cpt_pkg::RG_VA;
				r.degenerate = 1'b1;
				num = va;
			end else begin
				for (int i = 0; i < 3; i++) num[i] = base[i] + div_round(num[i], den);
			end
		end
		r.qx = clamp(num[0]);
		r.qy = clamp(num[1]);
		r.qz = clamp(num[2]);
		r.region = region;
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic void check_result(cpt_pkg::out_t got);
		cpt_pkg::out_t exp_r;
		if (expected_q.size() == 0) begin
			$display("%0t: result with no pending transaction: %p", $time, got);
			mismatches++;
			return;
		end
		exp_r = expected_q.pop_front();
		if (got.qx !== exp_r.qx) begin
			$display("%0t: qx expected %0d actual %0d", $time, exp_r.qx, got.qx);
			mismatches++;
		end
		if (got.qy !== exp_r.qy) begin
			$display("%0t: qy expected %0d actual %0d", $time, exp_r.qy, got.qy);
			mismatches++;
		end
		if (got.qz !== exp_r.qz) begin
			$display("%0t: qz expected %0d actual %0d", $time, exp_r.qz, got.qz);
			mismatches++;
		end
		if (got.region !== exp_r.region) begin
			$display("%0t: region expected %0d actual %0d", $time, exp_r.region, got.region);
			mismatches++;
		end
		if (got.degenerate !== exp_r.degenerate) begin
			$display("%0t: degenerate expected %0b actual %0b", $time,
				exp_r.degenerate, got.degenerate);
			mismatches++;
		end
	endfunction
endclass

@@ tb/tb_closest_point_on_triangle.sv @@
// ----------------------------------------------------------------------------
// tb_closest_point_on_triangle
// Directed and random queries through the closest-point block with random
// gaps on both sides; every popped result is checked against a prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_closest_point_on_triangle;
	import cpt_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	in_t  query = '0;
	out_t result;

	cpt_scoreboard sb = new();
	bit sending_done = 1'b0;
	bit burst = 1'b0;

	closest_point_on_triangle dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .query(query),
		.pop(pop), .empty(empty), .result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic in_t q16(int px, int py, int pz, int ax, int ay, int az,
			int bx, int by, int bz, int cx, int cy, int cz);
		in_t q;
		q = '{px <<< 16, py <<< 16, pz <<< 16, ax <<< 16, ay <<< 16, az <<< 16,
			bx <<< 16, by <<< 16, bz <<< 16, cx <<< 16, cy <<< 16, cz <<< 16};
		return q;
	endfunction

	function automatic cw_t rand_coord(int k);
		return cw_t'(int'($urandom_range(0, (2 << k) - 1)) - (1 << k));
	endfunction

	function automatic cw_t rand_extreme();
		case ($urandom_range(0, 4))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh00000000;
			3: return 32'shffffffff;
			default: return cw_t'($urandom);
		endcase
	endfunction

	function automatic in_t rand_query();
		in_t q;
		int k;
		k = $urandom_range(4, 24);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				q = '{rand_coord(k + 2), rand_coord(k + 2), rand_coord(k + 2),
					rand_coord(k), rand_coord(k), rand_coord(k),
					rand_coord(k), rand_coord(k), rand_coord(k),
					rand_coord(k), rand_coord(k), rand_coord(k)};
			end
			6, 7: begin
				q = '{cw_t'($urandom), cw_t'($urandom), cw_t'($urandom),
					cw_t'($urandom), cw_t'($urandom), cw_t'($urandom),
					cw_t'($urandom), cw_t'($urandom), cw_t'($urandom),
					cw_t'($urandom), cw_t'($urandom), cw_t'($urandom)};
			end
			8: begin
				q = '{rand_coord(k), rand_coord(k), rand_coord(k),
					rand_coord(k), rand_coord(k), rand_coord(k),
					rand_coord(k), rand_coord(k), rand_coord(k),
					rand_coord(k), rand_coord(k), rand_coord(k)};
				case ($urandom_range(0, 3))
					0: {q.bx, q.by_coord, q.bz} = {q.ax, q.ay, q.az};
					1: {q.cx, q.cy, q.cz} = {q.bx, q.by_coord, q.bz};
					2: {q.cx, q.cy, q.cz} = {q.ax, q.ay, q.az};
					default: begin
						q.cx = 2 * q.bx - q.ax;
						q.cy = 2 * q.by_coord - q.ay;
						q.cz = 2 * q.bz - q.az;
					end
				endcase
			end
			default: begin
				q = '{rand_extreme(), rand_extreme(), rand_extreme(),
					rand_extreme(), rand_extreme(), rand_extreme(),
					rand_extreme(), rand_extreme(), rand_extreme(),
					rand_extreme(), rand_extreme(), rand_extreme()};
			end
		endcase
		return q;
	endfunction

	function automatic int draw_gap();
		return burst ? 0 : $urandom_range(0, 13);
	endfunction

	task automatic send_query(in_t q);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		query <= q;
		do @(posedge clk); while (full);
		sb.note_query(q);
		@(negedge clk);
	endtask

	task automatic drain_results();
		int gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(result);
			@(negedge clk);
		end
	endtask

	initial begin
		in_t dir [$];
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		fork
			drain_results();
		join_none
		dir.insert(dir.size(), q16(-1, -1, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
		dir.insert(dir.size(), q16(11, -1, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
		dir.insert(dir.size(), q16(-1, 11, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
		dir.insert(dir.size(), q16(5, -1, 3, 0, 0, 0, 10, 0, 0, 0, 10, 0));
		dir.insert(dir.size(), q16(6, 6, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
		dir.insert(dir.size(), q16(-1, 5, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
		dir.insert(dir.size(), q16(2, 2, 5, 0, 0, 0, 10, 0, 0, 0, 10, 0));
		dir.insert(dir.size(), q16(3, 3, -7, 0, 0, 0, 10, 0, 0, 0, 10, 0));
		dir.insert(dir.size(), q16(1, 1, 0, 0, 0, 0, 1, 0, 0, 2, 0, 0));
		dir.insert(dir.size(), q16(1, 5, 2, 3, 3, 3, 3, 3, 3, 3, 3, 3));
		dir.insert(dir.size(), q16(1, 5, 2, 0, 0, 0, 4, 4, 4, 4, 4, 4));
		dir.insert(dir.size(), q16(5, 5, 0, 0, 0, 0, 0, 0, 0, 8, 0, 0));
		dir.insert(dir.size(), in_t'('0));
		dir.insert(dir.size(), in_t'('1));
		dir.insert(dir.size(), in_t'({12{32'h7fffffff}}));
		dir.insert(dir.size(), in_t'({12{32'h80000000}}));
		dir.insert(dir.size(), '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000});
		dir.insert(dir.size(), '{32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh80000000});
		dir.insert(dir.size(), '{32'sh00000000, 32'sh00000000, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh00000000,
			32'sh7fffffff, 32'sh80000000, 32'sh00000000,
			32'sh80000000, 32'sh7fffffff, 32'sh00000000});
		foreach (dir[i]) send_query(dir[i]);
		for (int n = 0; n < 1900; n++) begin
			if (n % 150 == 0) burst = ($urandom_range(0, 2) == 0);
			send_query(rand_query());
		end
		push <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin
		wait (sending_done);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/cpt_pkg.sv
rtl/core/cpt_front.sv
rtl/core/cpt_fifo.sv
rtl/core/cpt_back.sv
rtl/core/closest_point_on_triangle.sv
tb/cpt_scoreboard.sv
tb/tb_closest_point_on_triangle.sv
